FILE: hdl/ddpm_pkg.sv
// Shared types and constants for the differential drive PWM mixer.
package ddpm_pkg;

   // Q12 unity speed and saturating age limit
   localparam int SideLimit = 4096;
   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_MAX_ANGULAR    = 3'd0,
      CSR_TRACK_WIDTH    = 3'd1,
      CSR_DEADBAND       = 3'd2,
      CSR_MIN_DUTY       = 3'd3,
      CSR_DUTY_CEIL      = 3'd4,
      CSR_CHANGE_EPSILON = 3'd5,
      CSR_TIMEOUT_TICKS  = 3'd6
   } csr_index_type;

   // Operands for the shared multiplier
   typedef struct packed {
      logic signed [16:0] a;
      logic signed [13:0] b;
   } mul_req_type;

endpackage

FILE: hdl/ddpm_mul.sv
// Shared signed multiplier with a registered product.
module ddpm_mul
   import ddpm_pkg::*;
(
   input  logic               clock,
   input  mul_req_type        mul_req,
   output logic signed [30:0] product
);

   logic signed [30:0] product_ff;
   logic signed [30:0] product_in;

   // Form the product of the selected operands
   assign product_in = 31'(mul_req.a) * 31'(mul_req.b);

   // Hold the product for the next sequencer step
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

FILE: hdl/diff_drive_pwm_mixer_with_timeout.sv
// Top level: differential drive mixer, PWM duty mapping and command timeout.
// A velocity item (req_tuser 0) clamps and stores a linear speed and a yaw rate and
// arms the block; a tick item (req_tuser 1) ages the last command and, once armed,
// mixes the stored pair into left and right side speeds, maps them to 8-bit duties
// when either side moved by more than change_epsilon and performs a one-time safety
// stop once the age passes timeout_ticks. Each item gives exactly one result item
// carrying the held motor outputs and two flags in rsp_tuser. One signed multiplier is
// shared by the mix term and the two duty products under a small sequencer, so the
// block takes one item at a time: a velocity item passes ST_DONE, an unarmed tick
// ST_AGE and ST_DONE, an armed tick ST_MIX, ST_SIDES, the duty states on a rewrite,
// ST_AGE and ST_DONE, before req_tready rises again, and ST_DONE waits while the result
// register is still full. The next item is accepted while a finished result waits to be taken.
module diff_drive_pwm_mixer_with_timeout
   import ddpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] linear_speed, [31:16] angular_rate
   input  logic        req_tuser,   // 0 velocity command, 1 tick
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] left_duty, [8] left_forward,
                                    // [16:9] right_duty, [17] right_forward, zero pad
   output logic [1:0]  rsp_tuser    // [0] motors_rewritten, [1] timeout stop
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b00000001,
      ST_MIX      = 8'b00000010,
      ST_SIDES    = 8'b00000100,
      ST_DUTY_L   = 8'b00001000,
      ST_DUTY_R   = 8'b00010000,
      ST_DUTY_FIN = 8'b00100000,
      ST_AGE      = 8'b01000000,
      ST_DONE     = 8'b10000000
   } state_type;

   // Configuration registers
   logic [14:0] max_angular_ff;
   logic [12:0] track_width_ff;
   logic [12:0] deadband_ff;
   logic [7:0]  min_duty_ff;
   logic [7:0]  duty_ceil_ff;
   logic [12:0] change_epsilon_ff;
   logic [15:0] timeout_ticks_ff;

   // Control state
   state_type state_ff, state_in;
   logic      armed_ff, armed_in;
   logic      stopped_ff, stopped_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Speed and motor state
   logic signed [13:0] stored_linear_ff, stored_linear_in;
   logic signed [15:0] stored_angular_ff, stored_angular_in;
   logic signed [13:0] applied_left_ff, applied_left_in;
   logic signed [13:0] applied_right_ff, applied_right_in;
   logic [15:0]        command_age_ff, command_age_in;
   logic [7:0]         held_left_duty_ff, held_left_duty_in;
   logic [7:0]         held_right_duty_ff, held_right_duty_in;
   logic               held_left_dir_ff, held_left_dir_in;
   logic               held_right_dir_ff, held_right_dir_in;

   // Working registers for one tick
   logic signed [13:0] left_ff, left_in;
   logic signed [13:0] right_ff, right_in;
   logic               rewritten_ff, rewritten_in;
   logic               stop_now_ff, stop_now_in;

   // Result register
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   // Shared multiplier
   mul_req_type        mul_req;
   logic signed [30:0] product;

   // Datapath intermediates
   logic signed [15:0] req_linear;
   logic signed [15:0] req_angular;
   logic signed [16:0] ang_ext;
   logic signed [16:0] ang_lim;
   logic signed [17:0] mix_term;
   logic signed [18:0] lin_ext;
   logic signed [18:0] term_ext;
   logic signed [13:0] mix_left;
   logic signed [13:0] mix_right;
   logic signed [14:0] delta_left;
   logic signed [14:0] delta_right;
   logic [14:0]        delta_left_mag;
   logic [14:0]        delta_right_mag;
   logic [7:0]         span;
   logic [12:0]        mag_left;
   logic [12:0]        mag_right;
   logic [7:0]         duty_calc;
   logic [15:0]        age_next;

   ddpm_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   // Clamp a mixed side speed to plus or minus one Q12 unit
   function automatic logic signed [13:0] clamp_side(input logic signed [18:0] v);
      logic signed [13:0] r;
      if (v > 19'sd4096) begin
         r = 14'sd4096;
      end else if (v < -19'sd4096) begin
         r = -14'sd4096;
      end else begin
         r = v[13:0];
      end
      return r;
   endfunction

   // Magnitude of a clamped side speed
   function automatic logic [12:0] side_mag(input logic signed [13:0] v);
      logic signed [13:0] neg;
      neg = -v;
      return v[13] ? neg[12:0] : v[12:0];
   endfunction

   assign req_linear  = req_tdata[15:0];
   assign req_angular = req_tdata[31:16];
   assign ang_ext     = {req_angular[15], req_angular};
   assign ang_lim     = signed'({2'b00, max_angular_ff});

   // Mix term is a floor shift of the registered product
   assign mix_term  = product[30:13];
   assign lin_ext   = {{5{stored_linear_ff[13]}}, stored_linear_ff};
   assign term_ext  = {mix_term[17], mix_term};
   assign mix_left  = clamp_side(lin_ext - term_ext);
   assign mix_right = clamp_side(lin_ext + term_ext);

   assign delta_left      = 15'(mix_left) - 15'(applied_left_ff);
   assign delta_right     = 15'(mix_right) - 15'(applied_right_ff);
   assign delta_left_mag  = delta_left[14] ? 15'(-delta_left) : 15'(delta_left);
   assign delta_right_mag = delta_right[14] ? 15'(-delta_right) : 15'(delta_right);

   assign span      = (duty_ceil_ff > min_duty_ff) ? (duty_ceil_ff - min_duty_ff) : 8'd0;
   assign mag_left  = side_mag(left_ff);
   assign mag_right = side_mag(right_ff);

   // Duty from the product in flight, limited to the duty ceiling
   always_comb begin
      logic [8:0] sum;
      sum = {1'b0, min_duty_ff} + {1'b0, product[19:12]};
      if (sum > {1'b0, duty_ceil_ff}) begin
         duty_calc = duty_ceil_ff;
      end else begin
         duty_calc = sum[7:0];
      end
   end

   assign age_next = (command_age_ff == AGE_MAX) ? command_age_ff : command_age_ff + 16'd1;

   // Select multiplier operands for the current step
   always_comb begin
      mul_req.a = '0;
      mul_req.b = '0;
      case (state_ff)
         ST_MIX: begin
            mul_req.a = {stored_angular_ff[15], stored_angular_ff};
            mul_req.b = signed'({1'b0, track_width_ff});
         end
         ST_DUTY_L: begin
            mul_req.a = signed'({4'b0000, mag_left});
            mul_req.b = signed'({6'b000000, span});
         end
         ST_DUTY_R: begin
            mul_req.a = signed'({4'b0000, mag_right});
            mul_req.b = signed'({6'b000000, span});
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Sequence one item through the shared multiplier
   always_comb begin
      state_in           = state_ff;
      armed_in           = armed_ff;
      stopped_in         = stopped_ff;
      stored_linear_in   = stored_linear_ff;
      stored_angular_in  = stored_angular_ff;
      applied_left_in    = applied_left_ff;
      applied_right_in   = applied_right_ff;
      command_age_in     = command_age_ff;
      held_left_duty_in  = held_left_duty_ff;
      held_right_duty_in = held_right_duty_ff;
      held_left_dir_in   = held_left_dir_ff;
      held_right_dir_in  = held_right_dir_ff;
      left_in            = left_ff;
      right_in           = right_ff;
      rewritten_in       = rewritten_ff;
      stop_now_in        = stop_now_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_user_in        = rsp_user_ff;
      rsp_valid_in       = rsp_valid_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rewritten_in = 1'b0;
               stop_now_in  = 1'b0;
               if (!req_tuser) begin
                  // Velocity item: clamp and store, arm, clear the age
                  if (req_linear > 16'sd4096) begin
                     stored_linear_in = 14'sd4096;
                  end else if (req_linear < -16'sd4096) begin
                     stored_linear_in = -14'sd4096;
                  end else begin
                     stored_linear_in = req_linear[13:0];
                  end
                  if (ang_ext > ang_lim) begin
                     stored_angular_in = ang_lim[15:0];
                  end else if (ang_ext < -ang_lim) begin
                     stored_angular_in = 16'(-ang_lim);
                  end else begin
                     stored_angular_in = req_angular;
                  end
                  command_age_in = '0;
                  armed_in       = 1'b1;
                  state_in       = ST_DONE;
               end else if (armed_ff) begin
                  state_in = ST_MIX;
               end else begin
                  state_in = ST_AGE;
               end
            end
         end
         ST_MIX: begin
            state_in = ST_SIDES;
         end
         ST_SIDES: begin
            left_in  = mix_left;
            right_in = mix_right;
            if (delta_left_mag > {2'b00, change_epsilon_ff} ||
                delta_right_mag > {2'b00, change_epsilon_ff}) begin
               state_in = ST_DUTY_L;
            end else begin
               state_in = ST_AGE;
            end
         end
         ST_DUTY_L: begin
            state_in = ST_DUTY_R;
         end
         ST_DUTY_R: begin
            // Left product is ready
            if (mag_left <= deadband_ff) begin
               held_left_duty_in = '0;
            end else begin
               held_left_duty_in = duty_calc;
               held_left_dir_in  = !left_ff[13];
            end
            state_in = ST_DUTY_FIN;
         end
         ST_DUTY_FIN: begin
            // Right product is ready
            if (mag_right <= deadband_ff) begin
               held_right_duty_in = '0;
            end else begin
               held_right_duty_in = duty_calc;
               held_right_dir_in  = !right_ff[13];
            end
            applied_left_in  = left_ff;
            applied_right_in = right_ff;
            rewritten_in     = 1'b1;
            state_in         = ST_AGE;
         end
         ST_AGE: begin
            // Advance the age and stop once on timeout
            command_age_in = age_next;
            if (armed_ff && age_next > timeout_ticks_ff) begin
               if (!stopped_ff) begin
                  held_left_duty_in  = '0;
                  held_right_duty_in = '0;
                  stored_linear_in   = '0;
                  stored_angular_in  = '0;
                  applied_left_in    = '0;
                  applied_right_in   = '0;
                  stopped_in         = 1'b1;
                  stop_now_in        = 1'b1;
               end
            end else begin
               stopped_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Load the result once the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {6'b000000, held_right_dir_ff, held_right_duty_ff,
                               held_left_dir_ff, held_left_duty_ff};
               rsp_user_in  = {stop_now_ff, rewritten_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_angular_ff    <= 15'd16384;
         track_width_ff    <= 13'd2048;
         deadband_ff       <= 13'd20;
         min_duty_ff       <= 8'd45;
         duty_ceil_ff      <= 8'd255;
         change_epsilon_ff <= 13'd4;
         timeout_ticks_ff  <= 16'd1000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ANGULAR:    max_angular_ff    <= csr_wdata[14:0];
            CSR_TRACK_WIDTH:    track_width_ff    <= csr_wdata[12:0];
            CSR_DEADBAND:       deadband_ff       <= csr_wdata[12:0];
            CSR_MIN_DUTY:       min_duty_ff       <= csr_wdata[7:0];
            CSR_DUTY_CEIL:      duty_ceil_ff      <= csr_wdata[7:0];
            CSR_CHANGE_EPSILON: change_epsilon_ff <= csr_wdata[12:0];
            CSR_TIMEOUT_TICKS:  timeout_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control and motor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         armed_ff           <= 1'b0;
         stopped_ff         <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         stored_linear_ff   <= '0;
         stored_angular_ff  <= '0;
         applied_left_ff    <= '0;
         applied_right_ff   <= '0;
         command_age_ff     <= '0;
         held_left_duty_ff  <= '0;
         held_right_duty_ff <= '0;
         held_left_dir_ff   <= 1'b0;
         held_right_dir_ff  <= 1'b0;
         rewritten_ff       <= 1'b0;
         stop_now_ff        <= 1'b0;
      end else begin
         state_ff           <= state_in;
         armed_ff           <= armed_in;
         stopped_ff         <= stopped_in;
         rsp_valid_ff       <= rsp_valid_in;
         stored_linear_ff   <= stored_linear_in;
         stored_angular_ff  <= stored_angular_in;
         applied_left_ff    <= applied_left_in;
         applied_right_ff   <= applied_right_in;
         command_age_ff     <= command_age_in;
         held_left_duty_ff  <= held_left_duty_in;
         held_right_duty_ff <= held_right_duty_in;
         held_left_dir_ff   <= held_left_dir_in;
         held_right_dir_ff  <= held_right_dir_in;
         rewritten_ff       <= rewritten_in;
         stop_now_ff        <= stop_now_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A reported safety stop needs an armed block
   a_stop_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> armed_ff)
      else $error("safety stop reported while not armed");

   // Applied side speeds stay within one Q12 unit
   a_applied_range: assert property (@(posedge clock) disable iff (reset)
      (applied_left_ff <= 14'sd4096) && (applied_left_ff >= -14'sd4096) &&
      (applied_right_ff <= 14'sd4096) && (applied_right_ff >= -14'sd4096))
      else $error("applied side speed out of range");

   // An accepted item holds the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready after accepting an item");

endmodule
